>>> rtl/rcfs_pkg.sv
// shared types, constants and reset tables of the rc channel failsafe block
package rcfs_pkg;

	localparam int CHANNELS        = 18;
	localparam int FLIGHT_CHANNELS = 4;

	// index width, count width and width used for range compares on the 5-bit channel field
	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);
	localparam int CMP_W = 6;

	localparam int PULSE_W = 12;
	localparam int TIME_W  = 32;
	localparam int HOLD_W  = 16;
	localparam int CC_W    = 5;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MID_VALUE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 3'd4;

	// configuration reset values
	localparam logic [CC_W-1:0]    RST_CHANNEL_COUNT = 5'd18;
	localparam logic [PULSE_W-1:0] RST_MID_VALUE     = 12'd1500;
	localparam logic [PULSE_W-1:0] RST_MIN_PULSE     = 12'd885;
	localparam logic [PULSE_W-1:0] RST_MAX_PULSE     = 12'd2115;
	localparam logic [HOLD_W-1:0]  RST_HOLD_TIME     = 16'd300;

	// failsafe modes
	localparam logic [1:0] FS_AUTO = 2'd0;
	localparam logic [1:0] FS_HOLD = 2'd1;
	localparam logic [1:0] FS_SET  = 2'd2;

	// item functions
	localparam logic FUNC_SAMPLE   = 1'b0;
	localparam logic FUNC_TABLE_WR = 1'b1;

	// auto failsafe channel roles
	localparam int AUTO_MID_CHANNELS = 3;
	localparam int AUTO_THR_CHANNEL  = 3;

	typedef struct packed {
		logic               func;
		logic [4:0]         channel;
		logic [PULSE_W-1:0] pulse;
		logic [TIME_W-1:0]  now_ms;
		logic               link_ok;
		logic               failsafe_switch;
		logic               frame_end;
		logic [1:0]         fs_mode;
		logic [PULSE_W-1:0] fs_value;
	} in_item_t;

	typedef struct packed {
		logic [4:0]         out_channel;
		logic [PULSE_W-1:0] out_value;
		logic               flight_valid;
		logic               failsafe_applied;
		logic               run_last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic            capture;
		logic            exec;
		logic            emit;
		logic            frame_clr;
		logic [CH_W-1:0] idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic func;
		logic frame_end;
		logic none_active;
		logic last;
		logic slot_free;
	} sts_t;

	function automatic logic [PULSE_W-1:0] rst_channel_value(input int i);
		return (i == 3) ? 12'd885 : 12'd1500;
	endfunction

	function automatic logic [1:0] rst_fs_mode(input int i);
		return (i <= 3 || i == 7) ? FS_SET : FS_HOLD;
	endfunction

	function automatic logic [PULSE_W-1:0] rst_fs_value(input int i);
		if (i == 3)
			return 12'd987;
		else if (i == 7)
			return 12'd2000;
		else
			return 12'd1500;
	endfunction

	// failsafe value of one channel from its table entry
	function automatic logic [PULSE_W-1:0] fs_pick(
		input logic [1:0]         mode,
		input logic [CMP_W-1:0]   ch,
		input logic [PULSE_W-1:0] cur,
		input logic [PULSE_W-1:0] fsval,
		input logic [PULSE_W-1:0] mid,
		input logic [PULSE_W-1:0] minp
	);
		logic [PULSE_W-1:0] v;
		v = cur;
		if (mode == FS_SET)
			v = fsval;
		else if (mode == FS_AUTO && ch < CMP_W'(AUTO_MID_CHANNELS))
			v = mid;
		else if (mode == FS_AUTO && ch == CMP_W'(AUTO_THR_CHANNEL))
			v = minp;
		return v;
	endfunction

endpackage

>>> rtl/rcfs_if.sv
// request channel interfaces for samples and results
interface rcfs_in_if import rcfs_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rcfs_out_if import rcfs_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/rc_channel_failsafe_hold.sv
// top level of the rc channel failsafe with hold time
//
//  channel   | role   | carries
//  ----------+--------+-------------------------------------------
//  samples   | sink   | channel samples and failsafe table writes
//  results   | source | one value per active channel at frame end
//  cfg_*     | write  | channel_count, mid, min, max, hold time
//
// every request is accepted in the idle state, then executed on the state in S_EXEC
// frame end adds a readout of one result per active channel through the one
// shared read port of the channel state; a stalled result holds the readout
// the next request is taken while the last result still waits in its register
// reset loads the default tables and configuration at once, no clearing pass
module rc_channel_failsafe_hold import rcfs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	rcfs_in_if.sink               samples,
	rcfs_out_if.source            results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	rcfs_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (samples.valid),
		.sample_ready (samples.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	rcfs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.sample   (samples.data),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.results  (results)
	);

endmodule

>>> rtl/rcfs_datapath.sv
// channel state, failsafe tables, config registers and result register
module rcfs_datapath import rcfs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  in_item_t              sample,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rcfs_out_if.source            results
);

	in_item_t in_q;

	logic [CC_W-1:0]    channel_count_q;
	logic [PULSE_W-1:0] mid_q;
	logic [PULSE_W-1:0] min_q;
	logic [PULSE_W-1:0] max_q;
	logic [HOLD_W-1:0]  hold_q;

	logic [TIME_W-1:0]  deadline_q [CHANNELS];
	logic [PULSE_W-1:0] value_q    [CHANNELS];
	logic [1:0]         mode_q     [CHANNELS];
	logic [PULSE_W-1:0] fsval_q    [CHANNELS];
	logic               flight_ok_q;

	logic      out_valid_q;
	out_item_t out_q;

	logic [CH_W-1:0]    addr;
	logic [CMP_W-1:0]   addr_w;
	logic [CMP_W-1:0]   ch_w;
	logic [CMP_W-1:0]   active_w;
	logic [CNT_W-1:0]   active;
	logic [TIME_W-1:0]  rd_deadline;
	logic [PULSE_W-1:0] rd_value;
	logic [PULSE_W-1:0] fs_val;
	logic [TIME_W-1:0]  diff;
	logic               expired;
	logic               pulse_ok;
	logic               fs_all;
	logic               last;

	always_comb begin
		active_w = (CMP_W'(channel_count_q) < CMP_W'(CHANNELS)) ?
			CMP_W'(channel_count_q) : CMP_W'(CHANNELS);
		active   = active_w[CNT_W-1:0];
		ch_w     = CMP_W'(in_q.channel);
		addr     = cmd.exec ? in_q.channel[CH_W-1:0] : cmd.idx;
		addr_w   = CMP_W'(addr);
		rd_deadline = deadline_q[addr];
		rd_value    = value_q[addr];
		fs_val   = fs_pick(mode_q[addr], addr_w, rd_value, fsval_q[addr], mid_q, min_q);
		diff     = in_q.now_ms - rd_deadline;
		expired  = !diff[TIME_W-1];
		pulse_ok = in_q.link_ok && in_q.pulse >= min_q && in_q.pulse <= max_q;
		fs_all   = !flight_ok_q || in_q.failsafe_switch;
		last     = (CNT_W'(cmd.idx) + CNT_W'(1)) == active;
	end

	assign sts.func        = in_q.func;
	assign sts.frame_end   = in_q.frame_end;
	assign sts.none_active = (active == '0);
	assign sts.last        = last;
	assign sts.slot_free   = !out_valid_q || results.ready;

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	always_ff @(posedge clk) begin
		if (cmd.capture)
			in_q <= sample;
		if (cmd.emit) begin
			out_q.out_channel      <= 5'(cmd.idx);
			out_q.out_value        <= fs_all ? fs_val : rd_value;
			out_q.flight_valid     <= flight_ok_q;
			out_q.failsafe_applied <= fs_all;
			out_q.run_last         <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= RST_CHANNEL_COUNT;
			mid_q           <= RST_MID_VALUE;
			min_q           <= RST_MIN_PULSE;
			max_q           <= RST_MAX_PULSE;
			hold_q          <= RST_HOLD_TIME;
			for (int i = 0; i < CHANNELS; i++) begin
				deadline_q[i] <= TIME_W'(RST_HOLD_TIME);
				value_q[i]    <= rst_channel_value(i);
				mode_q[i]     <= rst_fs_mode(i);
				fsval_q[i]    <= rst_fs_value(i);
			end
			flight_ok_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CC_W-1:0];
					REG_MID_VALUE:     mid_q <= cfg_data[PULSE_W-1:0];
					REG_MIN_PULSE:     min_q <= cfg_data[PULSE_W-1:0];
					REG_MAX_PULSE:     max_q <= cfg_data[PULSE_W-1:0];
					REG_HOLD_TIME:     hold_q <= cfg_data[HOLD_W-1:0];
					default: ;
				endcase
			end

			if (cmd.exec) begin
				if (in_q.func == FUNC_TABLE_WR) begin
					if (ch_w < CMP_W'(CHANNELS)) begin
						mode_q[addr]  <= in_q.fs_mode;
						fsval_q[addr] <= in_q.fs_value;
					end
				end else if (ch_w < active_w) begin
					if (pulse_ok) begin
						deadline_q[addr] <= in_q.now_ms + TIME_W'(hold_q);
						value_q[addr]    <= in_q.pulse;
					end else if (expired) begin
						value_q[addr] <= fs_val;
						if (ch_w < CMP_W'(FLIGHT_CHANNELS))
							flight_ok_q <= 1'b0;
					end
				end
			end

			// whole-frame failsafe writes back while reading out
			if (cmd.emit && fs_all)
				value_q[addr] <= fs_val;

			if (cmd.frame_clr)
				flight_ok_q <= 1'b1;

			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/rcfs_controller.sv
// sequencer: request intake, item execution and frame readout
module rcfs_controller import rcfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0]      state_q;
	logic [CH_W-1:0] idx_q;

	assign sample_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.capture   = (state_q == S_IDLE) && sample_valid;
		cmd.exec      = (state_q == S_EXEC);
		cmd.emit      = (state_q == S_READ) && sts.slot_free;
		cmd.frame_clr = 1'b0;
		cmd.idx       = idx_q;
		if (state_q == S_EXEC && sts.func == FUNC_SAMPLE && sts.frame_end && sts.none_active)
			cmd.frame_clr = 1'b1;
		if (cmd.emit && sts.last)
			cmd.frame_clr = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (sample_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					idx_q <= '0;
					if (sts.func == FUNC_SAMPLE && sts.frame_end && !sts.none_active)
						state_q <= S_READ;
					else
						state_q <= S_IDLE;
				end
				S_READ: begin
					if (sts.slot_free) begin
						if (sts.last)
							state_q <= S_IDLE;
						else
							idx_q <= idx_q + CH_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
